>>> rtl/gbcb_pkg.sv
// ----------------------------------------------------------------------------
// gbcb_pkg
// Shared types and constants of the glyph bitmap color blend core.
// ----------------------------------------------------------------------------
package gbcb_pkg;

  localparam int LIM_W  = 13;  // pitch, row and column limits
  localparam int COLB_W = 16;  // pixel column within a glyph row
  localparam int SUM_W  = 20;  // coordinate sums before saturation

  localparam logic [1:0] MODE_MONO = 2'd0;
  localparam logic [1:0] MODE_GRAY = 2'd1;
  localparam logic [1:0] MODE_LCD  = 2'd2;

  localparam logic [2:0] REG_INK_RGB      = 3'd0;
  localparam logic [2:0] REG_PAPER_RGB    = 3'd1;
  localparam logic [2:0] REG_GLYPH_FORMAT = 3'd2;
  localparam logic [2:0] REG_BITMAP_WIDTH = 3'd3;
  localparam logic [2:0] REG_BITMAP_ROWS  = 3'd4;
  localparam logic [2:0] REG_ROW_PITCH    = 3'd5;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd6;
  localparam logic [2:0] REG_ORIGIN       = 3'd7;

  localparam logic [23:0] INK_RGB_RESET      = 24'h000000;
  localparam logic [23:0] PAPER_RGB_RESET    = 24'hFFFFFF;
  localparam logic [1:0]  GLYPH_FORMAT_RESET = MODE_GRAY;
  localparam logic [9:0]  ROW_PITCH_RESET    = 10'sd1;

  localparam logic [1:0] PHASE_RED   = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_MONO  = 2'd1,
    KIND_BLEND = 2'd2
  } gbcb_kind_t;

  typedef struct packed {
    logic take;
    logic eval;
    logic mono_load;
    logic mul;
    logic acc;
    logic blend_load;
  } gbcb_cmd_t;

  typedef struct packed {
    gbcb_kind_t kind;
    logic       mask_more;
    logic       out_free;
    logic       ch_last;
  } gbcb_stat_t;

endpackage

>>> rtl/glyph_bitmap_color_blend_core.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_color_blend_core
// Turns glyph bitmap bytes into colored, positioned screen pixels.
//
//   channel   signals                                   direction
//   item      item_valid, item_stall, coverage_byte     in
//   pixel     pixel_valid, pixel_stall, pixel_x/y,      out
//             red, green, blue, last_of_run
//   config    cfg_write, cfg_index, cfg_data            in
//
// A byte is taken in ST_IDLE and evaluated in the next cycle, in ST_EVAL. Mono
// bytes then give one pixel per cycle while the output is free. Gray and LCD
// pixels run the shared 8x9 multiplier once per channel. Bytes that make no
// pixel go back to idle after evaluation. Reset is synchronous; the output
// register holds a pixel under stall while the next byte is taken.
// ----------------------------------------------------------------------------
module glyph_bitmap_color_blend_core #(
  parameter int MAX_PITCH  = 256,
  parameter int MAX_ROWS   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         coverage_byte,
  output logic               pixel_valid,
  input  logic               pixel_stall,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               last_of_run
);
  import gbcb_pkg::*;

  gbcb_cmd_t  cmd;
  gbcb_stat_t stat;

  gbcb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  gbcb_datapath #(
    .MAX_PITCH  (MAX_PITCH),
    .MAX_ROWS   (MAX_ROWS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coverage_byte (coverage_byte),
    .cmd           (cmd),
    .stat          (stat),
    .pixel_stall   (pixel_stall),
    .pixel_valid   (pixel_valid),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_of_run   (last_of_run)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.mono_load || cmd.blend_load) |-> stat.out_free)
    else $error("output pixel overwritten before transfer");

  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (item_stall && cmd.eval))
    else $error("accepted byte not evaluated next cycle");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(cmd.mono_load || cmd.blend_load))
    else $error("pixel valid without a load");

  a_empty_byte_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && stat.kind == KIND_NONE) |=> !item_stall)
    else $error("byte without pixels did not release the input");

endmodule

>>> rtl/gbcb_ctrl.sv
// ----------------------------------------------------------------------------
// gbcb_ctrl
// Sequencer: takes a byte, evaluates it, then steps mono pixels out, runs
// the three-channel blend before presenting the pixel, or returns to idle.
// ----------------------------------------------------------------------------
module gbcb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  gbcb_pkg::gbcb_stat_t  stat,
  output gbcb_pkg::gbcb_cmd_t   cmd
);
  import gbcb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_MONO = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        case (stat.kind)
          KIND_MONO:  state_next = ST_MONO;
          KIND_BLEND: state_next = ST_MUL;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_MONO: begin
        if (stat.out_free) begin
          cmd.mono_load = 1'b1;
          if (!stat.mask_more) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.ch_last ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.blend_load = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/gbcb_datapath.sv
// ----------------------------------------------------------------------------
// gbcb_datapath
// Configuration registers, glyph position, mono bit mask, serial channel
// blend and the output pixel register.
// ----------------------------------------------------------------------------
module gbcb_datapath #(
  parameter int MAX_PITCH  = 256,
  parameter int MAX_ROWS   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [7:0]            coverage_byte,
  input  gbcb_pkg::gbcb_cmd_t   cmd,
  output gbcb_pkg::gbcb_stat_t  stat,
  input  logic                  pixel_stall,
  output logic                  pixel_valid,
  output logic signed [15:0]    pixel_x,
  output logic signed [15:0]    pixel_y,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  last_of_run
);
  import gbcb_pkg::*;

  localparam int COL_W = $clog2(MAX_PITCH + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int TRI_W = LIM_W + 2;
  localparam int EXT_W = (COORD_BITS + 1 > SUM_W) ? COORD_BITS + 1 : SUM_W;
  localparam logic [LIM_W-1:0] PITCH_CAP = LIM_W'(MAX_PITCH);
  localparam logic [LIM_W-1:0] ROWS_CAP  = LIM_W'(MAX_ROWS);
  localparam logic signed [EXT_W-1:0] SAT_HI =
    EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  // configuration
  logic [23:0] ink_rgb, paper_rgb;
  logic [1:0]  glyph_format;
  logic [11:0] bitmap_width;
  logic [8:0]  bitmap_rows;
  logic [9:0]  row_pitch;
  logic [11:0] cell_height;
  logic [31:0] origin;

  // glyph position
  logic [COL_W-1:0] byte_column, triple_column;
  logic [ROW_W-1:0] row_index;
  logic [1:0]       subpixel_phase;
  logic [7:0]       held_red, held_green;

  // per item
  logic [7:0]        cov;
  logic [7:0]        mask;
  logic [COLB_W-1:0] col_base;
  logic [15:0]       y_sat;
  logic [7:0]        bl_red, bl_green, bl_blue;
  logic [1:0]        channel;
  logic [17:0]       prod;
  logic [7:0]        res_red, res_green, res_blue;

  function automatic logic [15:0] sat16(input logic [SUM_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'($signed(v));
    if (e > SAT_HI) begin
      e = SAT_HI;
    end else if (e < SAT_LO) begin
      e = SAT_LO;
    end
    return e[15:0];
  endfunction

  logic [9:0]        pitch_mag, pitch_nz;
  logic [LIM_W-1:0]  pabs_raw, pabs, rows_ext, rows_eff;
  logic [LIM_W-1:0]  col_ext, col_inc, row_inc;
  logic              row_wrap, row_last, pitch_up, rows_zero;
  logic [SUM_W-1:0]  y_sum, y_shift, x_sum;
  logic [7:0]        mask_new;
  logic              gray_hit, lcd_in, lcd_hit;
  logic [TRI_W-1:0]  tri_end;
  gbcb_kind_t        kind;

  assign pitch_mag = row_pitch[9] ? (10'd0 - row_pitch) : row_pitch;
  assign pitch_nz  = (pitch_mag == 10'd0) ? 10'd1 : pitch_mag;
  assign pabs_raw  = LIM_W'(pitch_nz);
  assign pabs      = (pabs_raw > PITCH_CAP) ? PITCH_CAP : pabs_raw;
  assign rows_ext  = LIM_W'(bitmap_rows);
  assign rows_eff  = (rows_ext > ROWS_CAP) ? ROWS_CAP : rows_ext;
  assign rows_zero = (rows_eff == '0);
  assign pitch_up  = !row_pitch[9] && (row_pitch != 10'd0);

  assign col_ext  = LIM_W'(byte_column);
  assign col_inc  = col_ext + LIM_W'(1);
  assign row_wrap = (col_inc >= pabs);
  assign row_inc  = LIM_W'(row_index) + LIM_W'(1);
  assign row_last = (row_inc >= rows_eff);

  assign y_shift = pitch_up ? (SUM_W'(cell_height) - SUM_W'(rows_eff)) : '0;
  assign y_sum   = SUM_W'($signed(origin[31:16])) + SUM_W'(row_index) + y_shift;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask_new[b] = cov[7-b] &&
                    ({COLB_W'(col_ext), 3'(b)} < (COLB_W + 3)'(bitmap_width));
    end
  end

  assign gray_hit = (col_ext < LIM_W'(bitmap_width)) && (cov != 8'd0);
  assign tri_end  = TRI_W'({triple_column, 1'b0}) + TRI_W'(triple_column) + TRI_W'(3);
  assign lcd_in   = (tri_end <= TRI_W'(bitmap_width));
  assign lcd_hit  = lcd_in && (subpixel_phase == PHASE_BLUE) &&
                    ((held_red | held_green | cov) != 8'd0);

  always_comb begin
    kind = KIND_NONE;
    if (!rows_zero) begin
      case (glyph_format)
        MODE_MONO: kind = (mask_new != 8'd0) ? KIND_MONO : KIND_NONE;
        MODE_GRAY: kind = gray_hit ? KIND_BLEND : KIND_NONE;
        MODE_LCD:  kind = lcd_hit ? KIND_BLEND : KIND_NONE;
        default:   kind = KIND_NONE;
      endcase
    end
  end

  // leftmost remaining mono pixel
  logic [2:0] pick;
  logic [7:0] mask_rest;
  always_comb begin
    pick = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (mask[b]) begin
        pick = 3'(b);
      end
    end
  end
  assign mask_rest = mask & ~(8'b1 << pick);

  assign x_sum = SUM_W'($signed(origin[15:0])) + SUM_W'(col_base) +
                 (cmd.mono_load ? SUM_W'(pick) : '0);

  // channel blend: c*(f-b) + 255*b, then /255
  logic [7:0]        ch_cov, ch_fg, ch_bg;
  logic signed [8:0] ch_diff;
  logic signed [17:0] ch_prod;
  logic [17:0]       bg255, acc_sum;
  logic [16:0]       quot;
  always_comb begin
    case (channel)
      2'd0:    begin ch_cov = bl_red;   ch_fg = ink_rgb[7:0];   ch_bg = paper_rgb[7:0];   end
      2'd1:    begin ch_cov = bl_green; ch_fg = ink_rgb[15:8];  ch_bg = paper_rgb[15:8];  end
      default: begin ch_cov = bl_blue;  ch_fg = ink_rgb[23:16]; ch_bg = paper_rgb[23:16]; end
    endcase
  end
  assign ch_diff = {1'b0, ch_fg} - {1'b0, ch_bg};
  assign ch_prod = $signed({1'b0, ch_cov}) * ch_diff;
  assign bg255   = {2'b0, ch_bg, 8'd0} - {10'd0, ch_bg};
  assign acc_sum = prod + bg255;
  assign quot    = {1'b0, acc_sum[15:0]} + 17'd1 + {9'd0, acc_sum[15:8]};

  assign stat.kind      = kind;
  assign stat.mask_more = (mask_rest != 8'd0);
  assign stat.out_free  = !pixel_valid || !pixel_stall;
  assign stat.ch_last   = (channel == 2'd2);

  // configuration and glyph position
  always_ff @(posedge clk) begin
    if (rst) begin
      ink_rgb        <= INK_RGB_RESET;
      paper_rgb      <= PAPER_RGB_RESET;
      glyph_format   <= GLYPH_FORMAT_RESET;
      bitmap_width   <= '0;
      bitmap_rows    <= '0;
      row_pitch      <= ROW_PITCH_RESET;
      cell_height    <= '0;
      origin         <= '0;
      byte_column    <= '0;
      triple_column  <= '0;
      row_index      <= '0;
      subpixel_phase <= PHASE_RED;
      held_red       <= '0;
      held_green     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INK_RGB:      ink_rgb      <= cfg_data[23:0];
        REG_PAPER_RGB:    paper_rgb    <= cfg_data[23:0];
        REG_GLYPH_FORMAT: glyph_format <= cfg_data[1:0];
        REG_BITMAP_WIDTH: bitmap_width <= cfg_data[11:0];
        REG_BITMAP_ROWS:  bitmap_rows  <= cfg_data[8:0];
        REG_ROW_PITCH:    row_pitch    <= cfg_data[9:0];
        REG_CELL_HEIGHT:  cell_height  <= cfg_data[11:0];
        REG_ORIGIN:       origin       <= cfg_data;
        default:          origin       <= origin;
      endcase
      byte_column    <= '0;
      triple_column  <= '0;
      row_index      <= '0;
      subpixel_phase <= PHASE_RED;
      held_red       <= '0;
      held_green     <= '0;
    end else if (cmd.eval && !rows_zero) begin
      if (glyph_format == MODE_LCD && lcd_in) begin
        if (subpixel_phase == PHASE_RED) begin
          held_red <= cov;
        end else if (subpixel_phase == PHASE_GREEN) begin
          held_green <= cov;
        end
      end
      if (row_wrap) begin
        byte_column    <= '0;
        triple_column  <= '0;
        subpixel_phase <= PHASE_RED;
        row_index      <= row_last ? '0 : row_inc[ROW_W-1:0];
      end else begin
        byte_column <= col_inc[COL_W-1:0];
        if (subpixel_phase == PHASE_BLUE) begin
          subpixel_phase <= PHASE_RED;
          triple_column  <= triple_column + COL_W'(1);
        end else begin
          subpixel_phase <= subpixel_phase + 2'd1;
        end
      end
    end
  end

  // item work registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cov <= coverage_byte;
    end
    if (cmd.eval) begin
      mask    <= mask_new;
      y_sat   <= sat16(y_sum);
      channel <= 2'd0;
      case (glyph_format)
        MODE_MONO: col_base <= COLB_W'({col_ext, 3'd0});
        MODE_LCD:  col_base <= COLB_W'(triple_column);
        default:   col_base <= COLB_W'(col_ext);
      endcase
      if (glyph_format == MODE_LCD) begin
        bl_red   <= held_red;
        bl_green <= held_green;
      end else begin
        bl_red   <= cov;
        bl_green <= cov;
      end
      bl_blue <= cov;
    end
    if (cmd.mono_load) begin
      mask <= mask_rest;
    end
    if (cmd.mul) begin
      prod <= 18'(ch_prod);
    end
    if (cmd.acc) begin
      case (channel)
        2'd0:    res_red   <= quot[15:8];
        2'd1:    res_green <= quot[15:8];
        default: res_blue  <= quot[15:8];
      endcase
      channel <= stat.ch_last ? 2'd0 : channel + 2'd1;
    end
    if (cmd.mono_load) begin
      pixel_x     <= sat16(x_sum);
      pixel_y     <= y_sat;
      red         <= ink_rgb[7:0];
      green       <= ink_rgb[15:8];
      blue        <= ink_rgb[23:16];
      last_of_run <= (mask_rest == 8'd0);
    end else if (cmd.blend_load) begin
      pixel_x     <= sat16(x_sum);
      pixel_y     <= y_sat;
      red         <= res_red;
      green       <= res_green;
      blue        <= res_blue;
      last_of_run <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (cmd.mono_load || cmd.blend_load) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

endmodule

>>> test/glyph_bitmap_color_blend_core_tb.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_color_blend_core testbench
// Streams glyph bitmap bytes through the core under mono, gray, LCD and
// unused modes, predicts every colored pixel with a cycle-free model of the
// painter, and compares each pixel transfer against it in order. Both
// channels idle in random bursts; one long output hold fills the core.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbcb_pkg::*;

  localparam logic [1:0] MODE_UNUSED     = 2'd3;
  localparam int         GLYPH_MAX_PITCH = 256;
  localparam int         GLYPH_MAX_ROWS  = 256;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         LONG_HOLD       = 300;
  localparam int         RANDOM_ITEMS    = 280;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } pixel_t;

  class glyph_pixel_book;
    logic [23:0]       fg     = INK_RGB_RESET;
    logic [23:0]       bg     = PAPER_RGB_RESET;
    logic [1:0]        mode   = GLYPH_FORMAT_RESET;
    logic [11:0]       width  = '0;
    logic [8:0]        rows   = '0;
    logic signed [9:0] pitch  = ROW_PITCH_RESET;
    logic [11:0]       cell_h = '0;
    logic [31:0]       origin = '0;
    int                col    = 0;
    int                row    = 0;
    logic [1:0]        phase  = PHASE_RED;
    logic [7:0]        held_r = '0;
    logic [7:0]        held_g = '0;
    pixel_t            pending[$];
    int                mismatches = 0;

    function void restart();
      col    = 0;
      row    = 0;
      phase  = PHASE_RED;
      held_r = '0;
      held_g = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_INK_RGB:      fg     = d[23:0];
        REG_PAPER_RGB:    bg     = d[23:0];
        REG_GLYPH_FORMAT: mode   = d[1:0];
        REG_BITMAP_WIDTH: width  = d[11:0];
        REG_BITMAP_ROWS:  rows   = d[8:0];
        REG_ROW_PITCH:    pitch  = d[9:0];
        REG_CELL_HEIGHT:  cell_h = d[11:0];
        REG_ORIGIN:       origin = d;
        default: ;
      endcase
      restart();
    endfunction

    function logic [7:0] mix(logic [7:0] c, int shift);
      int f, b;
      f = int'((fg >> shift) & 24'hFF);
      b = int'((bg >> shift) & 24'hFF);
      return 8'((int'(c) * f + (255 - int'(c)) * b) / 255);
    endfunction

    function logic [15:0] clamp(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    endfunction

    function void add(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t e;
      e.x    = clamp(x);
      e.y    = clamp(y);
      e.r    = r;
      e.g    = g;
      e.b    = b;
      e.last = 1'b0;
      pending.push_back(e);
    endfunction

    function void take_byte(logic [7:0] cov);
      int rows_e, p, pabs, c, j, x0, y0, i, w3, first;
      rows_e = (rows > GLYPH_MAX_ROWS) ? GLYPH_MAX_ROWS : int'(rows);
      if (rows_e == 0) return;
      p    = pitch;
      pabs = (p < 0) ? -p : p;
      if (pabs == 0) pabs = 1;
      if (pabs > GLYPH_MAX_PITCH) pabs = GLYPH_MAX_PITCH;
      if (row >= rows_e) row = 0;
      if (col >= pabs) col = 0;
      c  = col;
      j  = row;
      x0 = $signed(origin[15:0]);
      y0 = $signed(origin[31:16]);
      y0 = y0 + j;
      if (p > 0) y0 = y0 + int'(cell_h) - rows_e;
      first = pending.size();
      case (mode)
        MODE_MONO: begin
          for (int k = 0; k < 8; k++) begin
            i = c * 8 + k;
            if (i < int'(width) && cov[7-k]) add(x0 + i, y0, fg[7:0], fg[15:8], fg[23:16]);
          end
        end
        MODE_GRAY: begin
          if (c < int'(width) && cov != 0) add(x0 + c, y0, mix(cov, 0), mix(cov, 8), mix(cov, 16));
        end
        MODE_LCD: begin
          w3 = int'(width) / 3 * 3;
          if (c < w3) begin
            if (phase == PHASE_RED) begin
              held_r = cov;
              phase  = PHASE_GREEN;
            end else if (phase == PHASE_GREEN) begin
              held_g = cov;
              phase  = PHASE_BLUE;
            end else begin
              if ((held_r | held_g | cov) != 0)
                add(x0 + c / 3, y0, mix(held_r, 0), mix(held_g, 8), mix(cov, 16));
              phase = PHASE_RED;
            end
          end
        end
        default: ;
      endcase
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
      col = c + 1;
      if (col >= pabs) begin
        col   = 0;
        phase = PHASE_RED;
        row   = j + 1;
        if (row >= rows_e) row = 0;
      end
    endfunction

    function void check(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void match_pixel(logic [15:0] x, logic [15:0] y, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic l);
      pixel_t e;
      if (pending.size() == 0) begin
        mismatches++;
        $error("pixel at (%0d, %0d) with none expected", $signed(x), $signed(y));
        return;
      end
      e = pending.pop_front();
      check("pixel_x", $signed(e.x), $signed(x));
      check("pixel_y", $signed(e.y), $signed(y));
      check("red", e.r, r);
      check("green", e.g, g);
      check("blue", e.b, b);
      check("last_of_run", e.last, l);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [7:0]         coverage_byte;
  logic               pixel_valid;
  logic               pixel_stall;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               last_of_run;

  glyph_pixel_book book;
  bit              quiet;
  bit              no_gaps;
  bit              hold_req;
  int              random_items;

  glyph_bitmap_color_blend_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .coverage_byte (coverage_byte),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL glyph_bitmap_color_blend_core");
    $finish;
  end

  // pixel receiver: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left  = 0;
    pixel_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        pixel_stall = 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pixel_stall = 1'b1;
        stall_left  = $urandom_range(1, 18) - 1;
      end else begin
        pixel_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall)
      book.match_pixel(pixel_x, pixel_y, red, green, blue, last_of_run);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    book.write_reg(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic configure(input logic [23:0] fg, input logic [23:0] bg, input logic [1:0] mode,
                           input int width, input int rows, input int pitch, input int cell_h,
                           input logic [15:0] ox, input logic [15:0] oy);
    write_reg(REG_INK_RGB, {8'd0, fg});
    write_reg(REG_PAPER_RGB, {8'd0, bg});
    write_reg(REG_GLYPH_FORMAT, {30'd0, mode});
    write_reg(REG_BITMAP_WIDTH, 32'(width) & 32'hFFF);
    write_reg(REG_BITMAP_ROWS, 32'(rows) & 32'h1FF);
    write_reg(REG_ROW_PITCH, 32'(pitch) & 32'h3FF);
    write_reg(REG_CELL_HEIGHT, 32'(cell_h) & 32'hFFF);
    write_reg(REG_ORIGIN, {oy, ox});
  endtask

  function automatic int pick_gap();
    if (quiet || no_gaps) return 0;
    if ($urandom_range(0, 5) == 0) return $urandom_range(1, 18);
    return 0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    @(negedge clk);
    item_valid    = 1'b1;
    coverage_byte = b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    book.take_byte(b);
  endtask

  task automatic send_list(input logic [7:0] bytes[$]);
    foreach (bytes[k]) send_byte(bytes[k]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  task automatic finish_phase();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random_phase(input int idx);
    int          sel, pmag, pitch, pabs_e, rows_v, rows_e, span, width, cell_h, glyph, bytes;
    logic [1:0]  mode;
    logic [23:0] fg, bg;
    logic [15:0] ox, oy;
    sel  = $urandom_range(0, 15);
    mode = (sel < 5) ? MODE_MONO : (sel < 10) ? MODE_GRAY : (sel < 15) ? MODE_LCD : MODE_UNUSED;
    case ($urandom_range(0, 19))
      0, 1:    pmag = 0;
      2:       pmag = $urandom_range(257, 511);
      default: pmag = $urandom_range(1, 6);
    endcase
    pitch  = $urandom_range(0, 1) ? -pmag : pmag;
    pabs_e = (pmag == 0) ? 1 : (pmag > GLYPH_MAX_PITCH) ? GLYPH_MAX_PITCH : pmag;
    case ($urandom_range(0, 19))
      0:       rows_v = 0;
      1:       rows_v = $urandom_range(257, 511);
      default: rows_v = $urandom_range(1, 4);
    endcase
    rows_e = (rows_v > GLYPH_MAX_ROWS) ? GLYPH_MAX_ROWS : rows_v;
    span   = (mode == MODE_MONO) ? pabs_e * 8 : pabs_e;
    width  = $urandom_range(0, span + 2);
    if ($urandom_range(0, 15) == 0) width = 4095;
    fg = 24'($urandom);
    bg = 24'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        fg = 24'hFFFFFF;
        bg = 24'h000000;
      end
      1: begin
        fg = 24'h000000;
        bg = 24'hFFFFFF;
      end
      default: ;
    endcase
    cell_h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) begin
      {oy, ox} = $urandom;
    end else begin
      ox = 16'(int'($urandom_range(0, 400)) - 200);
      oy = 16'(int'($urandom_range(0, 400)) - 200);
    end
    glyph = rows_e * pabs_e;
    if (rows_e == 0)
      bytes = 3;
    else if (glyph <= 40)
      bytes = glyph * $urandom_range(1, 2) + (($urandom_range(0, 2) == 0) ? $urandom_range(0, pabs_e) : 0);
    else
      bytes = $urandom_range(8, 30);
    if (bytes > 48) bytes = 48;
    configure(fg, bg, mode, width, rows_v, pitch, cell_h, ox, oy);
    for (int k = 0; k < bytes; k++) begin
      // sender pause until every pixel so far is out
      if (idx == 4 && k == bytes / 2) wait_drained();
      send_byte(pick_byte());
      if (rows_e != 0) random_items++;
    end
    finish_phase();
  endtask

  initial begin
    int phase_no;
    book          = new;
    quiet         = 1'b0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    random_items  = 0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_INK_RGB;
    cfg_data      = '0;
    item_valid    = 1'b0;
    coverage_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset registers: zero rows, bytes ignored
    send_list('{8'h5A, 8'hFF});
    finish_phase();

    // mono, width cut inside a byte, upward flow shift, row wrap
    configure(24'h3CA50F, 24'h000000, MODE_MONO, 13, 2, 2, 20, 16'hFFFB, 16'h0007);
    send_list('{8'hFF, 8'hFF, 8'h80, 8'h01, 8'h00, 8'hAA});
    finish_phase();

    // gray, padding byte, x saturating high, y at the low end
    configure(24'h563412, 24'hFFFFFF, MODE_GRAY, 3, 2, -4, 0, 16'h7FFE, 16'h8000);
    send_list('{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h40});
    finish_phase();

    // LCD, all-zero triple skipped, partial triple is padding
    configure(24'hFF8000, 24'h0000FF, MODE_LCD, 7, 1, 8, 1, 16'h0000, 16'h0000);
    send_list('{8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h55});
    finish_phase();

    // unused mode, zero pitch
    configure(24'h123456, 24'h654321, MODE_UNUSED, 8, 1, 0, 0, 16'h0010, 16'h0010);
    send_list('{8'h3C, 8'hC3});
    finish_phase();

    // oversized pitch and rows, widest bitmap
    configure(24'hFFFFFF, 24'h000000, MODE_MONO, 4095, 511, -512, 4095, 16'h8000, 16'h7FFF);
    send_list('{8'hFF, 8'h81});
    finish_phase();

    // upward flow pushing y past the top
    configure(24'h000000, 24'hFFFFFF, MODE_GRAY, 4095, 1, 511, 4095, 16'h8000, 16'h7FFF);
    send_list('{8'h01, 8'h00});
    finish_phase();

    // back-to-back bytes against a long output hold
    configure(24'($urandom), 24'($urandom), MODE_MONO, 16, 2, 2, 3, 16'h0005, 16'h0009);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 16; k++) begin
      send_byte(8'($urandom) | 8'h01);
      random_items++;
    end
    no_gaps = 1'b0;
    finish_phase();

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - 60) quiet = 1'b1;
      run_random_phase(phase_no);
      phase_no++;
    end

    wait_drained();
    repeat (24) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("PASS glyph_bitmap_color_blend_core");
    end else begin
      $display("FAIL glyph_bitmap_color_blend_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gbcb_pkg.sv
rtl/gbcb_ctrl.sv
rtl/gbcb_datapath.sv
rtl/glyph_bitmap_color_blend_core.sv
test/glyph_bitmap_color_blend_core_tb.sv
